/* rtl/cpi_pkg.sv */
// Shared types, codes and reset constants of the cassette port interface.
package cpi_pkg;

    localparam int TIME_W   = 64;
    localparam int DIV_W    = 16;
    localparam int SAMPLE_W = 32;
    localparam int LEN_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] KIND_PORT   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_REWIND = 2'd3;

    localparam logic [1:0] RES_RUN   = 2'd0;
    localparam logic [1:0] RES_INDEX = 2'd1;
    localparam logic [1:0] RES_BIT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_DIVIDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_DIVIDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LOW   = 3'd5;

    localparam logic [15:0] RST_OUT_DIVIDER = 16'd77;
    localparam logic [15:0] RST_OUT_LIMIT   = 16'd4410;
    localparam logic [6:0]  RST_OUT_OFFSET  = 7'd100;
    localparam logic [15:0] RST_IN_DIVIDER  = 16'd76;
    localparam logic [31:0] RST_THRESH_HIGH = 32'd128;
    localparam logic [31:0] RST_THRESH_LOW  = 32'd128;

    localparam int          TAPE_OUT_BIT = 1;
    localparam logic [7:0]  LEVEL_CENTER_HIGH = 8'd128;
    localparam logic [7:0]  LEVEL_CENTER_LOW  = 8'd127;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [DIV_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/cpi_divider.sv */
// Bit-serial restoring divider, 64-bit dividend by 16-bit divisor.
module cpi_divider
    import cpi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output div_stat_t         stat,
    output logic [TIME_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    rem_shift;
    logic [DIV_W:0]    rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TIME_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = CNT_W'(TIME_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DIV_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* rtl/cassette_port_interface.sv */
// Top level of the cassette port interface: registers, sequencer and result path.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | kind, cycle_time, port_bits, sample_value,
//           |                      | sample_missing
//  result   | out_valid/out_ready  | result_kind, run_length, run_level,
//           |                      | sample_index, tape_bit
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item that needs a division (a port write that flips the tape bit, or a read
// request after reading has started) goes through accept, division, finish and
// emit; a flip that gives an empty run skips the emit. A first read and a sample
// delivery go from accept to emit, other items end at the accept. A finished result
// waits in a staging register while a stalled consumer holds the output, and the
// next item is taken only once it has moved on. Control state resets asynchronously.
module cassette_port_interface
    import cpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [TIME_W-1:0]     cycle_time,
    input  logic [7:0]            port_bits,
    input  logic [SAMPLE_W-1:0]   sample_value,
    input  logic                  sample_missing,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [LEN_W-1:0]      run_length,
    output logic [7:0]            run_level,
    output logic [SAMPLE_W-1:0]   sample_index,
    output logic                  tape_bit,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [15:0] out_divider_reg;
    logic [15:0] out_limit_reg;
    logic [6:0]  out_offset_reg;
    logic [15:0] in_divider_reg;
    logic [31:0] thresh_high_reg;
    logic [31:0] thresh_low_reg;

    logic              last_out_bit_reg, last_out_bit_next;
    logic [TIME_W-1:0] last_edge_time_reg, last_edge_time_next;
    logic [TIME_W-1:0] read_start_time_reg, read_start_time_next;
    logic              read_started_reg, read_started_next;
    logic              last_in_level_reg, last_in_level_next;
    logic              op_port_reg, op_port_next;

    logic [1:0]          res_kind_reg, res_kind_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;
    logic [7:0]          res_level_reg, res_level_next;
    logic [SAMPLE_W-1:0] res_index_reg, res_index_next;
    logic                res_bit_reg, res_bit_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [7:0]          out_level_reg;
    logic [SAMPLE_W-1:0] out_index_reg;
    logic                out_bit_reg;
    logic                out_load;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [TIME_W-1:0] quotient;

    logic              in_fire;
    logic              new_bit;
    logic [15:0]       out_div_eff;
    logic [15:0]       in_div_eff;
    logic [LEN_W-1:0]  silence_len;
    logic              over_limit;
    logic [7:0]        level_high;
    logic [7:0]        level_low;

    cpi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;
    assign new_bit     = port_bits[TAPE_OUT_BIT];
    assign out_div_eff = (out_divider_reg == '0) ? 16'd1 : out_divider_reg;
    assign in_div_eff  = (in_divider_reg == '0) ? 16'd1 : in_divider_reg;
    assign silence_len = ({8'd0, out_limit_reg} << 5) + ({8'd0, out_limit_reg} << 4)
                       + ({8'd0, out_limit_reg} << 1);
    assign over_limit  = (quotient > {48'd0, out_limit_reg});
    assign level_high  = LEVEL_CENTER_HIGH + {1'b0, out_offset_reg};
    assign level_low   = LEVEL_CENTER_LOW - {1'b0, out_offset_reg};
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next           = state_reg;
        last_out_bit_next    = last_out_bit_reg;
        last_edge_time_next  = last_edge_time_reg;
        read_start_time_next = read_start_time_reg;
        read_started_next    = read_started_reg;
        last_in_level_next   = last_in_level_reg;
        op_port_next         = op_port_reg;
        res_kind_next        = res_kind_reg;
        res_len_next         = res_len_reg;
        res_level_next       = res_level_reg;
        res_index_next       = res_index_reg;
        res_bit_next         = res_bit_reg;
        div_req.start        = 1'b0;
        div_req.dividend     = cycle_time - last_edge_time_reg;
        div_req.divisor      = out_div_eff;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_len_next   = '0;
                    res_level_next = '0;
                    res_index_next = '0;
                    res_bit_next   = 1'b0;
                    unique case (kind)
                        KIND_PORT:
                        begin
                            if (new_bit != last_out_bit_reg)
                            begin
                                last_out_bit_next   = new_bit;
                                last_edge_time_next = cycle_time;
                                op_port_next        = 1'b1;
                                div_req.start       = 1'b1;
                                state_next          = ST_DIV;
                            end
                        end
                        KIND_READ:
                        begin
                            res_kind_next = RES_INDEX;
                            if (!read_started_reg)
                            begin
                                read_started_next    = 1'b1;
                                read_start_time_next = cycle_time;
                                state_next           = ST_EMIT;
                            end
                            else
                            begin
                                op_port_next     = 1'b0;
                                div_req.start    = 1'b1;
                                div_req.dividend = cycle_time - read_start_time_reg;
                                div_req.divisor  = in_div_eff;
                                state_next       = ST_DIV;
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            res_kind_next = RES_BIT;
                            state_next    = ST_EMIT;
                            priority if (sample_missing)
                            begin
                                read_started_next = 1'b0;
                                res_bit_next      = 1'b0;
                            end
                            else if (sample_value <= thresh_low_reg)
                            begin
                                last_in_level_next = 1'b0;
                                res_bit_next       = 1'b0;
                            end
                            else if (sample_value >= thresh_high_reg)
                            begin
                                last_in_level_next = 1'b1;
                                res_bit_next       = 1'b1;
                            end
                            else
                            begin
                                res_bit_next = last_in_level_reg;
                            end
                        end
                        KIND_REWIND:
                        begin
                            read_started_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (op_port_reg)
                    begin
                        res_kind_next = RES_RUN;
                        if (over_limit)
                        begin
                            res_len_next   = silence_len;
                            res_level_next = LEVEL_CENTER_HIGH;
                        end
                        else
                        begin
                            res_len_next   = {8'd0, quotient[15:0]};
                            res_level_next = last_out_bit_reg ? level_high : level_low;
                        end
                        if (over_limit ? (out_limit_reg == '0) : (quotient[15:0] == '0))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        res_kind_next  = RES_INDEX;
                        res_index_next = (quotient[TIME_W-1:SAMPLE_W] != '0) ?
                                         '1 : quotient[SAMPLE_W-1:0];
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            last_out_bit_reg    <= 1'b0;
            last_edge_time_reg  <= '0;
            read_start_time_reg <= '0;
            read_started_reg    <= 1'b0;
            last_in_level_reg   <= 1'b0;
            op_port_reg         <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            last_out_bit_reg    <= last_out_bit_next;
            last_edge_time_reg  <= last_edge_time_next;
            read_start_time_reg <= read_start_time_next;
            read_started_reg    <= read_started_next;
            last_in_level_reg   <= last_in_level_next;
            op_port_reg         <= op_port_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_divider_reg <= RST_OUT_DIVIDER;
            out_limit_reg   <= RST_OUT_LIMIT;
            out_offset_reg  <= RST_OUT_OFFSET;
            in_divider_reg  <= RST_IN_DIVIDER;
            thresh_high_reg <= RST_THRESH_HIGH;
            thresh_low_reg  <= RST_THRESH_LOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUT_DIVIDER: out_divider_reg <= cfg_data[15:0];
                REG_OUT_LIMIT:   out_limit_reg   <= cfg_data[15:0];
                REG_OUT_OFFSET:  out_offset_reg  <= cfg_data[6:0];
                REG_IN_DIVIDER:  in_divider_reg  <= cfg_data[15:0];
                REG_THRESH_HIGH: thresh_high_reg <= cfg_data;
                REG_THRESH_LOW:  thresh_low_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg  <= res_kind_next;
        res_len_reg   <= res_len_next;
        res_level_reg <= res_level_next;
        res_index_reg <= res_index_next;
        res_bit_reg   <= res_bit_next;
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_len_reg   <= res_len_reg;
            out_level_reg <= res_level_reg;
            out_index_reg <= res_index_reg;
            out_bit_reg   <= res_bit_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign run_length   = out_len_reg;
    assign run_level    = out_level_reg;
    assign sample_index = out_index_reg;
    assign tape_bit     = out_bit_reg;

endmodule

/* rtl/cpi_checker.sv */
// Port-level assertions for the cassette port interface and their bind.
module cpi_port_assertions
    import cpi_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [1:0]          kind,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          result_kind,
    input logic [LEN_W-1:0]    run_length,
    input logic [7:0]          run_level,
    input logic [SAMPLE_W-1:0] sample_index,
    input logic                tape_bit
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(run_length) && $stable(sample_index) && $stable(tape_bit))
        else $error("Stalled result item changed or dropped.");

    a_busy_after_result_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_READ || kind == KIND_SAMPLE) |=> !in_ready)
        else $error("Block ready right after an item that must give a result.");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind != 2'd3)
        else $error("Result item carries an undefined kind.");

    a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_RUN |->
            run_length != '0 && sample_index == '0 && tape_bit == 1'b0)
        else $error("Run item is empty or carries stray fields.");

    a_bit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_BIT |->
            run_length == '0 && run_level == '0 && sample_index == '0)
        else $error("Tape bit item carries stray fields.");

endmodule

bind cassette_port_interface cpi_port_assertions u_cpi_port_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .run_length   (run_length),
    .run_level    (run_level),
    .sample_index (sample_index),
    .tape_bit     (tape_bit)
);

/* verif/cpi_checker.sv */
// Checker for the cassette port interface: predicts each result from the accepted items.
`timescale 1ns / 1ps

module cpi_checker
    import cpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [TIME_W-1:0]     cycle_time,
    input  logic [7:0]            port_bits,
    input  logic [SAMPLE_W-1:0]   sample_value,
    input  logic                  sample_missing,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            result_kind,
    input  logic [LEN_W-1:0]      run_length,
    input  logic [7:0]            run_level,
    input  logic [SAMPLE_W-1:0]   sample_index,
    input  logic                  tape_bit,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    due_count
);

    localparam int SILENCE_FACTOR = 50;

    typedef struct packed {
        logic [1:0]          rkind;
        logic [LEN_W-1:0]    length;
        logic [7:0]          level;
        logic [SAMPLE_W-1:0] index;
        logic                tape;
    } tape_result_t;

    tape_result_t results_due[$];
    tape_result_t head;

    logic [15:0]         out_div;
    logic [15:0]         out_lim;
    logic [6:0]          out_offset;
    logic [15:0]         in_div;
    logic [31:0]         th_high;
    logic [31:0]         th_low;

    logic                out_bit;
    logic [TIME_W-1:0]   edge_time;
    logic [TIME_W-1:0]   read_t0;
    logic                reading;
    logic                in_level;

    function automatic logic [63:0] divisor_of(input logic [15:0] d);
        return (d == 16'd0) ? 64'd1 : {48'd0, d};
    endfunction

    task automatic cassette_step(input logic [1:0] k, input logic [63:0] t,
                                 input logic [7:0] pb, input logic [31:0] sv,
                                 input logic miss);
        tape_result_t r;
        logic         nb;
        logic [63:0]  q;
        logic [31:0]  len;
        logic [7:0]   lvl;
        r = '0;
        case (k)
            KIND_PORT:
            begin
                nb = pb[TAPE_OUT_BIT];
                if (nb != out_bit)
                begin
                    out_bit = nb;
                    q = (t - edge_time) / divisor_of(out_div);
                    edge_time = t;
                    if (q > {48'd0, out_lim})
                    begin
                        len = {16'd0, out_lim} * SILENCE_FACTOR;
                        lvl = LEVEL_CENTER_HIGH;
                    end
                    else
                    begin
                        len = q[31:0];
                        lvl = nb ? LEVEL_CENTER_HIGH + {1'b0, out_offset}
                                 : LEVEL_CENTER_LOW - {1'b0, out_offset};
                    end
                    if (len != 32'd0)
                    begin
                        r.rkind = RES_RUN;
                        r.length = len[LEN_W-1:0];
                        r.level = lvl;
                        results_due.push_back(r);
                    end
                end
            end
            KIND_READ:
            begin
                if (!reading)
                begin
                    reading = 1'b1;
                    read_t0 = t;
                    q = 64'd0;
                end
                else
                begin
                    q = (t - read_t0) / divisor_of(in_div);
                    if (q > 64'hFFFF_FFFF)
                        q = 64'hFFFF_FFFF;
                end
                r.rkind = RES_INDEX;
                r.index = q[31:0];
                results_due.push_back(r);
            end
            KIND_SAMPLE:
            begin
                if (miss)
                begin
                    reading = 1'b0;
                    r.tape = 1'b0;
                end
                else if (sv <= th_low)
                begin
                    in_level = 1'b0;
                    r.tape = 1'b0;
                end
                else if (sv >= th_high)
                begin
                    in_level = 1'b1;
                    r.tape = 1'b1;
                end
                else
                begin
                    r.tape = in_level;
                end
                r.rkind = RES_BIT;
                results_due.push_back(r);
            end
            default:
            begin
                reading = 1'b0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_div = RST_OUT_DIVIDER;
            out_lim = RST_OUT_LIMIT;
            out_offset = RST_OUT_OFFSET;
            in_div = RST_IN_DIVIDER;
            th_high = RST_THRESH_HIGH;
            th_low = RST_THRESH_LOW;
            out_bit = 1'b0;
            edge_time = '0;
            read_t0 = '0;
            reading = 1'b0;
            in_level = 1'b0;
            results_due.delete();
            fail_count = 0;
            due_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result_kind %0d arrived with no item awaiting a result",
                           result_kind);
                    fail_count++;
                end
                else
                begin
                    head = results_due.pop_front();
                    check_field("result_kind", head.rkind, result_kind);
                    check_field("run_length", head.length, run_length);
                    check_field("run_level", head.level, run_level);
                    check_field("sample_index", head.index, sample_index);
                    check_field("tape_bit", head.tape, tape_bit);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OUT_DIVIDER: out_div = cfg_data[15:0];
                    REG_OUT_LIMIT:   out_lim = cfg_data[15:0];
                    REG_OUT_OFFSET:  out_offset = cfg_data[6:0];
                    REG_IN_DIVIDER:  in_div = cfg_data[15:0];
                    REG_THRESH_HIGH: th_high = cfg_data;
                    REG_THRESH_LOW:  th_low = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                cassette_step(kind, cycle_time, port_bits, sample_value, sample_missing);
            due_count = results_due.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the cassette port interface: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import cpi_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int DRAIN_WAIT  = 100;
    localparam int LONG_HOLD   = 1500;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            kind;
    logic [TIME_W-1:0]     cycle_time;
    logic [7:0]            port_bits;
    logic [SAMPLE_W-1:0]   sample_value;
    logic                  sample_missing;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            result_kind;
    logic [LEN_W-1:0]      run_length;
    logic [7:0]            run_level;
    logic [SAMPLE_W-1:0]   sample_index;
    logic                  tape_bit;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    due_count;

    logic                  no_idle = 1'b0;
    logic                  hold_req = 1'b0;

    logic [15:0]           cur_out_div;
    logic [15:0]           cur_out_lim;
    logic [15:0]           cur_in_div;
    logic [31:0]           cur_th_high;
    logic [31:0]           cur_th_low;

    cassette_port_interface dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .cycle_time(cycle_time), .port_bits(port_bits),
        .sample_value(sample_value), .sample_missing(sample_missing),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .run_length(run_length), .run_level(run_level),
        .sample_index(sample_index), .tape_bit(tape_bit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cpi_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .cycle_time(cycle_time), .port_bits(port_bits),
        .sample_value(sample_value), .sample_missing(sample_missing),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .run_length(run_length), .run_level(run_level),
        .sample_index(sample_index), .tape_bit(tape_bit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .due_count(due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // The result side stalls at random and, when asked, holds off for a long stretch.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 99) < 15)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic [1:0] k, input logic [63:0] t, input logic [7:0] pb,
                         input logic [31:0] sv, input logic miss);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        cycle_time <= t;
        port_bits <= pb;
        sample_value <= sv;
        sample_missing <= miss;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 40)
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    initial
    begin
        int          p;
        int          i;
        int          sel;
        logic [63:0] cpu_time;
        logic [63:0] span;
        logic [63:0] delta;
        logic [15:0] od;
        logic [1:0]  k;
        logic [7:0]  pb;
        logic [31:0] sv;
        logic        miss;
        logic        tb_out_bit;
        logic        last_was_read;
        logic [31:0] v_od, v_ol, v_off, v_id, v_th, v_tl;

        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_PORT;
        cycle_time = '0;
        port_bits = '0;
        sample_value = '0;
        sample_missing = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_OUT_DIVIDER;
        cfg_data = '0;
        cur_out_div = RST_OUT_DIVIDER;
        cur_out_lim = RST_OUT_LIMIT;
        cur_in_div = RST_IN_DIVIDER;
        cur_th_high = RST_THRESH_HIGH;
        cur_th_low = RST_THRESH_LOW;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items run on the reset register values.
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0000_0001);
        offer(KIND_PORT,   64'd0,      8'h00, 32'h0,         1'b0);
        offer(KIND_PORT,   64'd10,     8'hFF, 32'hFFFF_FFFF, 1'b1);
        offer(KIND_PORT,   64'd20,     8'h02, 32'h0,         1'b0);
        offer(KIND_PORT,   64'd3865,   8'hFD, 32'h0,         1'b0);
        offer(KIND_PORT,   64'd343435, 8'h02, 32'h0,         1'b0);
        offer(KIND_PORT,   64'd683082, 8'h00, 32'h0,         1'b0);
        offer(KIND_READ,   64'd700000, 8'hFF, 32'h0,         1'b0);
        offer(KIND_READ,   64'd776000, 8'h00, 32'h0,         1'b0);
        offer(KIND_SAMPLE, 64'd776100, 8'h00, 32'd128,       1'b0);
        offer(KIND_SAMPLE, 64'd776200, 8'h00, 32'd129,       1'b0);
        offer(KIND_SAMPLE, 64'd776300, 8'h00, 32'hFFFF_FFFF, 1'b0);
        offer(KIND_SAMPLE, 64'd776400, 8'h00, 32'h0,         1'b0);
        offer(KIND_SAMPLE, 64'd776500, 8'h00, 32'hFFFF_FFFF, 1'b1);
        offer(KIND_READ,   64'd800000, 8'h00, 32'h0,         1'b0);
        offer(KIND_READ,   64'd800000 + 64'hFFFF_FFFF_0000_0000, 8'h00, 32'h0, 1'b0);
        offer(KIND_REWIND, 64'd900000, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        offer(KIND_SAMPLE, 64'd900100, 8'h00, 32'd200,       1'b0);
        offer(KIND_PORT,   64'hFFFF_FFFF_FFFF_FFFF, 8'h02, 32'h0, 1'b0);
        offer(KIND_PORT,   64'd1000,   8'h00, 32'h0,         1'b0);
        offer(KIND_READ,   64'd5,      8'h00, 32'h0,         1'b0);
        offer(KIND_READ,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0, 1'b0);
        offer(KIND_READ,   64'd4,      8'h00, 32'h0,         1'b0);
        cpu_time = 64'd1000;
        tb_out_bit = 1'b0;
        last_was_read = 1'b0;

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd77, 32'd4410, 32'd100, 32'd76, 32'd128, 32'd128};
                1: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0};
                2: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd65535, 32'd65535, 32'd127, 32'd65535,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF};
                3: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd0, 32'd20, 32'd64, 32'd0, 32'd200, 32'd100};
                4: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd13, 32'd300, 32'd5, 32'd9, 32'd100, 32'd300};
                5:
                begin
                    v_od = $urandom;
                    v_ol = $urandom;
                    v_off = $urandom;
                    v_id = $urandom;
                    v_th = $urandom;
                    v_tl = $urandom;
                end
                6:
                begin
                    v_od = $urandom_range(1, 65535);
                    v_ol = $urandom_range(0, 2000);
                    v_off = $urandom_range(0, 127);
                    v_id = $urandom_range(1, 65535);
                    v_tl = $urandom_range(0, 1000);
                    v_th = v_tl + $urandom_range(0, 500);
                end
                default: {v_od, v_ol, v_off, v_id, v_th, v_tl} =
                       {32'd77, 32'd4410, 32'd100, 32'd76, 32'd140, 32'd116};
            endcase
            write_reg(REG_OUT_DIVIDER, v_od);
            write_reg(REG_OUT_LIMIT, v_ol);
            write_reg(REG_OUT_OFFSET, v_off);
            write_reg(REG_IN_DIVIDER, v_id);
            write_reg(REG_THRESH_HIGH, v_th);
            write_reg(REG_THRESH_LOW, v_tl);
            cur_out_div = v_od[15:0];
            cur_out_lim = v_ol[15:0];
            cur_in_div = v_id[15:0];
            cur_th_high = v_th;
            cur_th_low = v_tl;
            no_idle = (p == 4);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == 40)
                    hold_req = 1'b1;
                if (p == 2 && i == 100)
                    settle();

                od = (cur_out_div == 16'd0) ? 16'd1 : cur_out_div;
                sel = $urandom_range(0, 99);
                if (sel < 45)
                begin
                    span = 64'(od) * (64'(cur_out_lim) + 64'd2);
                    delta = {$urandom, $urandom} % (span + 64'd1);
                end
                else if (sel < 70)
                    delta = 64'($urandom_range(0, 3 * int'(od)));
                else if (sel < 90)
                    delta = 64'($urandom_range(0, 300)) * 64'(cur_in_div);
                else if (sel < 97)
                    delta = 64'($urandom);
                else
                    delta = {$urandom, $urandom} - cpu_time;
                cpu_time = cpu_time + delta;

                // A read request is mostly followed by the delivery of its sample.
                sel = $urandom_range(0, 99);
                if (last_was_read && sel < 70)
                    k = KIND_SAMPLE;
                else if (sel < 40)
                    k = KIND_PORT;
                else if (sel < 65)
                    k = KIND_READ;
                else if (sel < 93)
                    k = KIND_SAMPLE;
                else
                    k = KIND_REWIND;
                last_was_read = (k == KIND_READ);

                pb = $urandom;
                if (k == KIND_PORT)
                begin
                    if ($urandom_range(0, 99) < 75)
                        pb[TAPE_OUT_BIT] = ~tb_out_bit;
                    tb_out_bit = pb[TAPE_OUT_BIT];
                end

                sel = $urandom_range(0, 9);
                case (sel)
                    0: sv = cur_th_low;
                    1: sv = cur_th_low + 32'd1;
                    2: sv = cur_th_high;
                    3: sv = cur_th_high - 32'd1;
                    4: sv = cur_th_low + (cur_th_high - cur_th_low) / 2;
                    5: sv = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    default: sv = $urandom;
                endcase
                miss = ($urandom_range(0, 99) < 8);

                offer(k, cpu_time, pb, sv, miss);
            end
        end

        settle();
        if (fail_count == 0 && due_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
